// ----- sv/slal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential list package
// Shared types, codes and defaults for the bounded append/remove list.
// ----------------------------------------------------------------------------
package slal_pkg;

   localparam int LIST_CAPACITY = 10;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_APPENDED  = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_REMOVED   = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  entry_count;
      logic [31:0] append_total;
      logic [3:0]  removed_position;
   } rsp_type;

   typedef enum logic [2:0] {
      CTRL_IDLE,
      CTRL_DECIDE,
      CTRL_READ,
      CTRL_COMPARE,
      CTRL_SHIFT_READ,
      CTRL_SHIFT_WRITE
   } ctrl_state_type;

   typedef struct packed {
      logic       load;
      logic       mem_read;
      logic       append_write;
      logic       shift_write;
      logic       index_clear;
      logic       index_step;
      logic       position_capture;
      logic       length_decrement;
      logic       respond;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic is_remove;
      logic full;
      logic empty;
      logic match;
      logic last;
   } sts_type;

endpackage

// ----- sv/slal_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential list controller
// State machine that steps the datapath through append, search and shift.
// ----------------------------------------------------------------------------
module slal_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  slal_pkg::sts_type sts,
   output slal_pkg::cmd_type cmd
);
   import slal_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTRL_IDLE: begin
            if (start) begin
               state_in = CTRL_DECIDE;
            end
         end
         CTRL_DECIDE: begin
            if (sts.is_remove && !sts.empty) begin
               state_in = CTRL_READ;
            end else begin
               state_in = CTRL_IDLE;
            end
         end
         CTRL_READ: begin
            state_in = CTRL_COMPARE;
         end
         CTRL_COMPARE: begin
            if (sts.last) begin
               state_in = CTRL_IDLE;
            end else if (sts.match) begin
               state_in = CTRL_SHIFT_READ;
            end else begin
               state_in = CTRL_READ;
            end
         end
         CTRL_SHIFT_READ: begin
            state_in = CTRL_SHIFT_WRITE;
         end
         CTRL_SHIFT_WRITE: begin
            if (sts.last) begin
               state_in = CTRL_IDLE;
            end else begin
               state_in = CTRL_SHIFT_READ;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rsp_status = STATUS_APPENDED;
      busy = 1'b1;
      case (state_ff)
         CTRL_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
         end
         CTRL_DECIDE: begin
            if (!sts.is_remove) begin
               cmd.respond = 1'b1;
               if (sts.full) begin
                  cmd.rsp_status = STATUS_FULL;
               end else begin
                  cmd.append_write = 1'b1;
                  cmd.rsp_status = STATUS_APPENDED;
               end
            end else if (sts.empty) begin
               cmd.respond = 1'b1;
               cmd.rsp_status = STATUS_NOT_FOUND;
            end else begin
               cmd.index_clear = 1'b1;
            end
         end
         CTRL_READ: begin
            cmd.mem_read = 1'b1;
         end
         CTRL_COMPARE: begin
            if (sts.match) begin
               cmd.position_capture = 1'b1;
               if (sts.last) begin
                  cmd.length_decrement = 1'b1;
                  cmd.respond = 1'b1;
                  cmd.rsp_status = STATUS_REMOVED;
               end else begin
                  cmd.index_step = 1'b1;
               end
            end else if (sts.last) begin
               cmd.respond = 1'b1;
               cmd.rsp_status = STATUS_NOT_FOUND;
            end else begin
               cmd.index_step = 1'b1;
            end
         end
         CTRL_SHIFT_READ: begin
            cmd.mem_read = 1'b1;
         end
         CTRL_SHIFT_WRITE: begin
            cmd.shift_write = 1'b1;
            if (sts.last) begin
               cmd.length_decrement = 1'b1;
               cmd.respond = 1'b1;
               cmd.rsp_status = STATUS_REMOVED;
            end else begin
               cmd.index_step = 1'b1;
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ----- sv/slal_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential list datapath
// Entry memory, length and append counters, scan index and result register.
// ----------------------------------------------------------------------------
module slal_dpath #(
   parameter int CAPACITY = slal_pkg::LIST_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  slal_pkg::req_type req_data,
   input  slal_pkg::cmd_type cmd,
   output slal_pkg::sts_type sts,
   output logic              rsp_strobe,
   output slal_pkg::rsp_type rsp_data
);
   import slal_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W = $clog2(CAPACITY + 1);

   logic [31:0]      mem [CAPACITY];
   logic [31:0]      rd_data_ff;
   logic             op_ff;
   logic [31:0]      value_ff;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic [31:0]      total_ff;
   logic [31:0]      total_in;
   logic [LEN_W-1:0] idx_ff;
   logic [LEN_W-1:0] idx_prev;
   logic [LEN_W:0]   idx_next;
   logic [LEN_W-1:0] pos_ff;
   logic [LEN_W-1:0] pos_in;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_data;
   logic             wr_en;

   assign idx_next = {1'b0, idx_ff} + (LEN_W + 1)'(1);
   assign idx_prev = idx_ff - LEN_W'(1);

   assign sts.is_remove = (op_ff == OP_REMOVE);
   assign sts.full      = (len_ff == LEN_W'(CAPACITY));
   assign sts.empty     = (len_ff == '0);
   assign sts.match     = (rd_data_ff == value_ff);
   assign sts.last      = (idx_next >= {1'b0, len_ff});

   assign wr_en   = cmd.append_write || cmd.shift_write;
   assign wr_addr = cmd.append_write ? len_ff[IDX_W-1:0] : idx_prev[IDX_W-1:0];
   assign wr_data = cmd.append_write ? value_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= mem[idx_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      len_in = len_ff;
      total_in = total_ff;
      if (cmd.append_write) begin
         len_in = len_ff + LEN_W'(1);
         if (total_ff != '1) begin
            total_in = total_ff + 32'd1;
         end
      end else if (cmd.length_decrement) begin
         len_in = len_ff - LEN_W'(1);
      end
      pos_in = cmd.position_capture ? idx_ff : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_data.opcode;
         value_ff <= req_data.item_value;
      end
      if (cmd.index_clear) begin
         idx_ff <= '0;
      end else if (cmd.index_step) begin
         idx_ff <= idx_next[LEN_W-1:0];
      end
      pos_ff <= pos_in;
      if (cmd.respond) begin
         rsp_ff.status       <= cmd.rsp_status;
         rsp_ff.entry_count  <= 4'(len_in);
         rsp_ff.append_total <= total_in;
         rsp_ff.removed_position <=
            (cmd.rsp_status == STATUS_REMOVED) ? 4'(pos_in) : 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         len_ff        <= len_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- sv/sequential_list_append_remove.sv -----
`timescale 1ns / 1ps
// An append, or any request refused at once, holds busy only in the decide state
// and its response strobes in the first cycle after busy falls.
// A remove holds busy while it scans the entries and shifts the later ones down:
// the single-port entry memory costs a read and a compare or write per entry.
// The response strobe cannot be stalled.
// Reset empties the list and clears the append total; entries are not cleared.
// ----------------------------------------------------------------------------
// Sequential list with append and remove
// Bounded ordered list; removes the first matching entry and closes the gap.
// ----------------------------------------------------------------------------
module sequential_list_append_remove #(
   parameter int CAPACITY = slal_pkg::LIST_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  slal_pkg::req_type req_data,
   output logic              rsp_strobe,
   output slal_pkg::rsp_type rsp_data
);
   import slal_pkg::*;

   cmd_type cmd;
   sts_type sts;

   slal_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   slal_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response strobe without a request in progress");

   a_append_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == STATUS_APPENDED)
         |-> (rsp_data.append_total != 32'd0) && (rsp_data.entry_count != 4'd0
              || CAPACITY > 15))
      else $error("append reported without count or length");

   a_position_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != STATUS_REMOVED)
         |-> (rsp_data.removed_position == 4'd0))
      else $error("position reported for a request that removed nothing");

endmodule
